// File: rtl/asv_pkg.sv
// Package for the ASN.1 string type validator.
// Holds the character class codes, the queue word type and the character set checks.
// No dependencies.
package asv_pkg;

  localparam logic [2:0] CLS_NONE      = 3'd0;
  localparam logic [2:0] CLS_UTF8      = 3'd1;
  localparam logic [2:0] CLS_UCS4      = 3'd2;
  localparam logic [2:0] CLS_BMP       = 3'd3;
  localparam logic [2:0] CLS_NUMERIC   = 3'd4;
  localparam logic [2:0] CLS_PRINTABLE = 3'd5;
  localparam logic [2:0] CLS_IA5       = 3'd6;
  localparam logic [2:0] CLS_VISIBLE   = 3'd7;

  localparam logic [7:0] TAG_UTF8      = 8'd12;
  localparam logic [7:0] TAG_NUMERIC   = 8'd18;
  localparam logic [7:0] TAG_PRINTABLE = 8'd19;
  localparam logic [7:0] TAG_IA5       = 8'd22;
  localparam logic [7:0] TAG_VISIBLE   = 8'd26;
  localparam logic [7:0] TAG_UCS4      = 8'd28;
  localparam logic [7:0] TAG_BMP       = 8'd30;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [31:0] CODE_MAX    = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO     = 32'h0000_D800;
  localparam logic [31:0] SURR_HI     = 32'h0000_DFFF;

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } asv_word_t;

  function automatic logic [2:0] classify(input logic [7:0] tag);
    logic [2:0] c;
    case (tag)
      TAG_UTF8:      c = CLS_UTF8;
      TAG_UCS4:      c = CLS_UCS4;
      TAG_BMP:       c = CLS_BMP;
      TAG_NUMERIC:   c = CLS_NUMERIC;
      TAG_PRINTABLE: c = CLS_PRINTABLE;
      TAG_IA5:       c = CLS_IA5;
      TAG_VISIBLE:   c = CLS_VISIBLE;
      default:       c = CLS_NONE;
    endcase
    return c;
  endfunction

  function automatic logic scalar_ok(input logic [31:0] c);
    return (c != 32'd0) && (c <= CODE_MAX) && !((c >= SURR_LO) && (c <= SURR_HI));
  endfunction

  function automatic logic [31:0] min_code(input logic [1:0] m);
    logic [31:0] v;
    case (m)
      2'd1:    v = 32'h0000_0080;
      2'd2:    v = 32'h0000_0800;
      2'd3:    v = 32'h0001_0000;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic printable_char(input logic [7:0] c);
    logic alnum;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A);
    return alnum || c == 8'h20 || c == 8'h27 || c == 8'h28 || c == 8'h29 ||
           c == 8'h2B || c == 8'h2C || c == 8'h2D || c == 8'h2E || c == 8'h2F ||
           c == 8'h3A || c == 8'h3D || c == 8'h3F;
  endfunction

endpackage

// File: rtl/asv_in_if.sv
// Input channel of the ASN.1 string type validator: one string item per word.
// Depends on nothing.
interface asv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] string_tag;
  logic       has_byte;
  logic       last;

  modport source(output valid, data_byte, string_tag, has_byte, last, input ready);
  modport sink(input valid, data_byte, string_tag, has_byte, last, output ready);
endinterface

// File: rtl/asv_out_if.sv
// Output channel of the ASN.1 string type validator: one verdict per string.
// Depends on nothing.
interface asv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source(output valid, valid_res, input ready);
  modport sink(input valid, valid_res, output ready);
endinterface

// File: rtl/asn1_string_type_validator_top.sv
// Top level of the ASN.1 string type validator: front end, word queue and decoder.
// Depends on asv_pkg, asv_in_if, asv_out_if, asv_front, asv_fifo and asv_back.
//
//   port    direction  word contents                                 handshake
//   in_ch   sink       data_byte, string_tag, has_byte, last         valid/ready
//   out_ch  source     valid_res, one per string                     valid/ready
//
// One word is taken per cycle while the queue is not full; a verdict is registered when the
// decoder takes the word ending its string from the queue.
// The decoder takes one queued word per cycle while the queue is not empty.
// The queue holds QUEUE_DEPTH words; the input stalls only when it is full.
// A waiting verdict stalls the decoder only at the next string end.
// Reset is synchronous and empties the queue and all decode state.
module asn1_string_type_validator_top
  import asv_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input logic       clk,
  input logic       rst,
  asv_in_if.sink    in_ch,
  asv_out_if.source out_ch
);

  asv_word_t front_word;
  asv_word_t head_word;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  asv_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .word  (front_word)
  );

  asv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (front_word),
    .pop       (pop),
    .head      (head_word),
    .full      (full),
    .empty     (empty)
  );

  asv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .word   (head_word),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/asv_front.sv
// Front end: accepts input words, tracks string boundaries and tags each word with its class.
// Depends on asv_pkg and asv_in_if.
module asv_front
  import asv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  asv_in_if.sink    in_ch,
  input  logic      full,
  output logic      push,
  output asv_word_t word
);

  logic       in_string;
  logic [2:0] tag_class;

  assign in_ch.ready    = !full;
  assign push           = in_ch.valid && !full;
  assign word.cls       = in_string ? tag_class : classify(in_ch.string_tag);
  assign word.data_byte = in_ch.data_byte;
  assign word.has_byte  = in_ch.has_byte;
  assign word.last      = in_ch.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_string <= 1'b0;
      tag_class <= CLS_NONE;
    end else if (push) begin
      tag_class <= word.cls;
      in_string <= !in_ch.last;
    end
  end

endmodule

// File: rtl/asv_fifo.sv
// Short queue of classified words between the front end and the decoder.
// Depends on asv_pkg.
module asv_fifo
  import asv_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  asv_word_t push_word,
  input  logic      pop,
  output asv_word_t head,
  output logic      full,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  asv_word_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/asv_back.sv
// Back end: decodes the queued words of a string and registers the verdict for the output.
// Depends on asv_pkg and asv_out_if.
module asv_back
  import asv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  asv_word_t word,
  input  logic      empty,
  output logic      pop,
  asv_out_if.source out_ch
);

  logic [1:0]  pend;
  logic [31:0] acc;
  logic [1:0]  minc;
  logic [1:0]  gpos;
  logic        failed;
  logic        got;
  logic        out_valid;
  logic        out_res;

  logic [1:0]  pend_next;
  logic [31:0] acc_next;
  logic [1:0]  minc_next;
  logic [1:0]  gpos_next;
  logic        failed_next;
  logic        got_next;
  logic        verdict;
  logic [31:0] cont_code;
  logic [31:0] group_code;
  logic        group_done;
  logic [7:0]  b;

  assign out_ch.valid     = out_valid;
  assign out_ch.valid_res = out_res;
  assign pop = !empty && (!word.last || !out_valid || out_ch.ready);

  assign b          = word.data_byte;
  assign cont_code  = {acc[25:0], b[5:0]};
  assign group_code = {acc[23:0], b};
  assign group_done = (word.cls == CLS_UCS4) ? (gpos == 2'd3) : (gpos == 2'd1);

  always_comb begin
    pend_next   = pend;
    acc_next    = acc;
    minc_next   = minc;
    gpos_next   = gpos;
    failed_next = failed;
    got_next    = got;
    if (word.has_byte) begin
      got_next = 1'b1;
      if (!failed) begin
        case (word.cls)
          CLS_UTF8: begin
            if (pend == 2'd0) begin
              if (b < 8'h80) begin
                failed_next = (b == 8'h00);
              end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                pend_next = 2'd1;
                minc_next = 2'd1;
                acc_next  = {27'd0, b[4:0]};
              end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                pend_next = 2'd2;
                minc_next = 2'd2;
                acc_next  = {28'd0, b[3:0]};
              end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                pend_next = 2'd3;
                minc_next = 2'd3;
                acc_next  = {29'd0, b[2:0]};
              end else begin
                failed_next = 1'b1;
              end
            end else if (b[7:6] != 2'b10) begin
              failed_next = 1'b1;
            end else begin
              pend_next = pend - 2'd1;
              if (pend == 2'd1) begin
                failed_next = (cont_code < min_code(minc)) || !scalar_ok(cont_code);
                acc_next    = '0;
                minc_next   = 2'd0;
              end else begin
                acc_next = cont_code;
              end
            end
          end
          CLS_UCS4, CLS_BMP: begin
            if (group_done) begin
              failed_next = !scalar_ok(group_code);
              acc_next    = '0;
              gpos_next   = 2'd0;
            end else begin
              acc_next  = group_code;
              gpos_next = gpos + 2'd1;
            end
          end
          CLS_NUMERIC: begin
            failed_next = !((b >= 8'h30 && b <= 8'h39) || b == 8'h20);
          end
          CLS_PRINTABLE: begin
            failed_next = !printable_char(b);
          end
          CLS_IA5: begin
            failed_next = (b == 8'h00) || (b > 8'h7F);
          end
          CLS_VISIBLE: begin
            failed_next = (b < 8'h20) || (b > 8'h7E);
          end
          default: begin
            failed_next = 1'b1;
          end
        endcase
      end
    end
    verdict = !failed_next && got_next && (word.cls != CLS_NONE) &&
              (pend_next == 2'd0) && (gpos_next == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 2'd0;
      acc       <= '0;
      minc      <= 2'd0;
      gpos      <= 2'd0;
      failed    <= 1'b0;
      got       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && word.last) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (word.last) begin
          pend   <= 2'd0;
          acc    <= '0;
          minc   <= 2'd0;
          gpos   <= 2'd0;
          failed <= 1'b0;
          got    <= 1'b0;
        end else begin
          pend   <= pend_next;
          acc    <= acc_next;
          minc   <= minc_next;
          gpos   <= gpos_next;
          failed <= failed_next;
          got    <= got_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && word.last) begin
      out_res <= verdict;
    end
  end

endmodule

// File: verif/asn1_string_type_validator_top_tb.sv
// Self-checking testbench for asn1_string_type_validator_top: drives ASN.1 string words and
// checks every verdict against a cycle-free predictor of the string rules.
// Depends on asv_pkg, asv_in_if, asv_out_if and the validator RTL.
`timescale 1ns / 100ps

module asn1_string_type_validator_top_tb;
  import asv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int END_PAUSE = 20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] string_tag;
    logic       has_byte;
    logic       last;
  } str_word_t;

  logic clk;
  logic rst;

  asv_in_if in_ch();
  asv_out_if out_ch();

  asn1_string_type_validator_top dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  str_word_t   word_q[$];
  logic        verdict_q[$];
  logic [7:0]  str_bytes[$];
  str_word_t   cur_word;
  logic        want_res;
  int          words_taken = 0;
  int          total_words = 1;
  int          mismatches = 0;
  int          hold_left = 0;
  bit          hold_done = 0;
  int unsigned cycle_cnt = 0;

  string numeric_set = "0123456789 ";
  string printable_set =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 '()+,-./:=?";

  // Predictor state for the string in progress.
  logic [2:0]  str_cls;
  logic [1:0]  cont_left;
  logic [31:0] code_acc;
  logic [31:0] code_floor;
  logic [1:0]  grp_pos;
  logic        str_bad;
  logic        in_str;
  logic        seen_byte;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [2:0] class_of_tag(input logic [7:0] tag);
    case (tag)
      TAG_UTF8:      return CLS_UTF8;
      TAG_UCS4:      return CLS_UCS4;
      TAG_BMP:       return CLS_BMP;
      TAG_NUMERIC:   return CLS_NUMERIC;
      TAG_PRINTABLE: return CLS_PRINTABLE;
      TAG_IA5:       return CLS_IA5;
      TAG_VISIBLE:   return CLS_VISIBLE;
      default:       return CLS_NONE;
    endcase
  endfunction

  function automatic logic code_legal(input logic [31:0] cp);
    return cp != 0 && cp <= 32'h10FFFF && (cp < 32'hD800 || cp > 32'hDFFF);
  endfunction

  function automatic logic printable_ok(input logic [7:0] b);
    if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
      return 1'b1;
    end
    case (b)
      " ", "'", "(", ")", "+", ",", "-", ".", "/", ":", "=", "?": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_string();
    str_cls = CLS_NONE;
    cont_left = 2'd0;
    code_acc = 32'd0;
    code_floor = 32'd0;
    grp_pos = 2'd0;
    str_bad = 1'b0;
    in_str = 1'b0;
    seen_byte = 1'b0;
  endtask

  task automatic utf8_take(input logic [7:0] b);
    if (cont_left == 0) begin
      if (b < 8'h80) begin
        if (b == 8'h00) str_bad = 1'b1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        cont_left = 2'd1;
        code_floor = 32'h80;
        code_acc = {27'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cont_left = 2'd2;
        code_floor = 32'h800;
        code_acc = {28'd0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        cont_left = 2'd3;
        code_floor = 32'h10000;
        code_acc = {29'd0, b[2:0]};
      end else begin
        str_bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      str_bad = 1'b1;
    end else begin
      code_acc = {code_acc[25:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) begin
        if (code_acc < code_floor || !code_legal(code_acc)) str_bad = 1'b1;
        code_acc = 32'd0;
        code_floor = 32'd0;
      end
    end
  endtask

  task automatic group_take(input logic [7:0] b, input int width);
    code_acc = {code_acc[23:0], b};
    if (grp_pos + 1 >= width) begin
      if (!code_legal(code_acc)) str_bad = 1'b1;
      code_acc = 32'd0;
      grp_pos = 2'd0;
    end else begin
      grp_pos = grp_pos + 2'd1;
    end
  endtask

  task automatic judge_word(input str_word_t w);
    logic [7:0] b;
    b = w.data_byte;
    if (!in_str) begin
      clear_string();
      str_cls = class_of_tag(w.string_tag);
      in_str = 1'b1;
    end
    if (w.has_byte) begin
      seen_byte = 1'b1;
      if (!str_bad) begin
        case (str_cls)
          CLS_UTF8:      utf8_take(b);
          CLS_UCS4:      group_take(b, 4);
          CLS_BMP:       group_take(b, 2);
          CLS_NUMERIC:   if (!((b >= "0" && b <= "9") || b == " ")) str_bad = 1'b1;
          CLS_PRINTABLE: if (!printable_ok(b)) str_bad = 1'b1;
          CLS_IA5:       if (b == 8'h00 || b > 8'h7F) str_bad = 1'b1;
          CLS_VISIBLE:   if (b < 8'h20 || b > 8'h7E) str_bad = 1'b1;
          default:       str_bad = 1'b1;
        endcase
      end
    end
    if (w.last) begin
      verdict_q.push_back(!str_bad && seen_byte && str_cls != CLS_NONE &&
                          cont_left == 0 && grp_pos == 0);
      clear_string();
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic [7:0] tag, input logic has,
                           input logic last);
    str_word_t w;
    w.data_byte = b;
    w.string_tag = tag;
    w.has_byte = has;
    w.last = last;
    word_q.push_back(w);
  endtask

  // Turns str_bytes into words; with gaps, byte-less words are sprinkled in and later
  // words carry a random tag, which the block must ignore.
  task automatic emit_string(input logic [7:0] tag, input bit gaps);
    int n;
    bit first;
    bit empty_tail;
    n = str_bytes.size();
    first = 1'b1;
    empty_tail = gaps && $urandom_range(0, 2) == 0;
    if (n == 0) begin
      push_word(8'($urandom_range(0, 255)), tag, 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (gaps && $urandom_range(0, 3) == 0) begin
          push_word(8'($urandom_range(0, 255)), first ? tag : 8'($urandom_range(0, 255)),
                    1'b0, 1'b0);
          first = 1'b0;
        end
        push_word(str_bytes[i], first ? tag : (gaps ? 8'($urandom_range(0, 255)) : tag),
                  1'b1, i == n - 1 && !empty_tail);
        first = 1'b0;
      end
      if (empty_tail) begin
        push_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
    end
    str_bytes.delete();
  endtask

  task automatic put_utf8(input logic [31:0] cp, input int len);
    case (len)
      1: str_bytes.push_back(cp[7:0]);
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [31:0] pick_code(input bit noise);
    case ($urandom_range(0, noise ? 9 : 6))
      0, 1: return $urandom_range(1, 'h7F);
      2: return $urandom_range('h80, 'h7FF);
      3: return $urandom_range('h800, 'hD7FF);
      4: return $urandom_range('hE000, 'hFFFF);
      5: return $urandom_range('h10000, 'h10FFFF);
      6: begin
        case ($urandom_range(0, 7))
          0: return 32'h1;
          1: return 32'h7F;
          2: return 32'h80;
          3: return 32'h7FF;
          4: return 32'h800;
          5: return 32'hD7FF;
          6: return 32'hE000;
          default: return 32'h10FFFF;
        endcase
      end
      7: return $urandom_range('hD800, 'hDFFF);
      8: begin
        case ($urandom_range(0, 2))
          0: return 32'h0;
          1: return 32'h110000;
          default: return $urandom;
        endcase
      end
      default: return $urandom_range('h110000, 'h1FFFFF);
    endcase
  endfunction

  function automatic int idle_phase();
    if (words_taken * 3 < total_words) return 0;
    if (words_taken * 3 < total_words * 2) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      0: return 16;
      1: return 66;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (idle_phase())
      0: return 66;
      1: return 16;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        judge_word(cur_word);
        words_taken++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_word = word_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= cur_word.data_byte;
          in_ch.string_tag <= cur_word.string_tag;
          in_ch.has_byte <= cur_word.has_byte;
          in_ch.last <= cur_word.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, got %0b", $time, out_ch.valid_res);
          mismatches++;
        end else begin
          want_res = verdict_q.pop_front();
          if (out_ch.valid_res !== want_res) begin
            $display("%0t: valid_res mismatch, expected %0b, got %0b", $time, want_res,
                     out_ch.valid_res);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_phase() == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(0, 99) >= recv_idle_pct();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL asn1_string_type_validator_top");
      $finish;
    end
  end

  initial begin
    int nchar;
    bit noise;
    bit gaps;
    logic [7:0] tag;
    logic [31:0] cp;
    int len;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.string_tag = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    clear_string();

    push_word(8'h00, TAG_UTF8, 1'b0, 1'b1);
    push_word(8'h41, 8'hFF, 1'b1, 1'b1);
    push_word(8'hC2, TAG_UTF8, 1'b1, 1'b0);
    push_word(8'h5A, 8'h00, 1'b0, 1'b0);
    push_word(8'h80, 8'h00, 1'b1, 1'b1);
    str_bytes = '{8'hE0, 8'h80, 8'h80};
    emit_string(TAG_UTF8, 1'b0);
    str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    emit_string(TAG_UTF8, 1'b0);
    str_bytes = '{8'hC3};
    emit_string(TAG_UTF8, 1'b0);
    str_bytes = '{8'hFF, 8'h41};
    emit_string(TAG_UTF8, 1'b0);
    str_bytes = '{8'h00, 8'h41, 8'h7A};
    emit_string(TAG_BMP, 1'b0);
    str_bytes = '{8'h00, 8'h10, 8'hFF, 8'hFF};
    emit_string(TAG_UCS4, 1'b0);
    str_bytes = '{8'h30, 8'h39, 8'h20};
    emit_string(TAG_NUMERIC, 1'b0);
    str_bytes = '{8'h3F, 8'h2B};
    emit_string(TAG_PRINTABLE, 1'b0);
    push_word(8'h7F, TAG_IA5, 1'b1, 1'b0);
    push_word(8'hFF, 8'h00, 1'b0, 1'b1);
    str_bytes = '{8'h7F};
    emit_string(TAG_VISIBLE, 1'b0);

    while (word_q.size() < 430) begin
      noise = $urandom_range(0, 99) < 20;
      gaps = $urandom_range(0, 3) == 0;
      nchar = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
      case ($urandom_range(0, 7))
        0: begin
          tag = TAG_UTF8;
          for (int i = 0; i < nchar; i++) begin
            cp = pick_code(noise);
            len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
            if (noise && len < 4 && $urandom_range(0, 2) == 0) len++;
            put_utf8(cp, len);
          end
        end
        1: begin
          tag = TAG_UCS4;
          for (int i = 0; i < nchar; i++) begin
            cp = pick_code(noise);
            for (int k = 3; k >= 0; k--) str_bytes.push_back(cp[8*k +: 8]);
          end
        end
        2: begin
          tag = TAG_BMP;
          for (int i = 0; i < nchar; i++) begin
            cp = pick_code(noise);
            if (!noise && cp > 'hFFFF) cp = $urandom_range('hE000, 'hFFFF);
            str_bytes.push_back(cp[15:8]);
            str_bytes.push_back(cp[7:0]);
          end
        end
        3, 4, 5, 6: begin
          case ($urandom_range(0, 3))
            0: tag = TAG_NUMERIC;
            1: tag = TAG_PRINTABLE;
            2: tag = TAG_IA5;
            default: tag = TAG_VISIBLE;
          endcase
          for (int i = 0; i < nchar; i++) begin
            if (noise && $urandom_range(0, 3) == 0) begin
              str_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (tag == TAG_NUMERIC) begin
              str_bytes.push_back(numeric_set[$urandom_range(0, numeric_set.len() - 1)]);
            end else if (tag == TAG_PRINTABLE) begin
              str_bytes.push_back(printable_set[$urandom_range(0, printable_set.len() - 1)]);
            end else if (tag == TAG_IA5) begin
              str_bytes.push_back(8'($urandom_range(1, 127)));
            end else begin
              str_bytes.push_back(8'($urandom_range(32, 126)));
            end
          end
        end
        default: begin
          tag = 8'($urandom_range(0, 255));
          for (int i = 0; i < nchar; i++) str_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      if (noise) begin
        case ($urandom_range(0, 5))
          0: if (str_bytes.size() != 0) void'(str_bytes.pop_back());
          1: begin
            if (str_bytes.size() != 0) begin
              str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            end
          end
          2: str_bytes.delete();
          default: ;
        endcase
      end
      emit_string(tag, gaps);
    end
    total_words = word_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (!(word_q.size() == 0 && !in_ch.valid && verdict_q.size() == 0));
    repeat (END_PAUSE) @(posedge clk);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("PASS asn1_string_type_validator_top");
    end else begin
      $display("FAIL asn1_string_type_validator_top");
    end
    $finish;
  end

endmodule
